[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

[design/hsv_pkg.sv]
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared constants, types and register indexes for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int HueW   = 13;
  localparam int ChanW  = 8;
  localparam int RemW   = 10;
  localparam int SecW   = 3;
  localparam int IdxW   = 8;
  localparam int ProdW  = 18;
  localparam int LevelW = 26;
  localparam int RecipW = 27;
  localparam int RecipK = 44;

  localparam logic [HueW-1:0]  HueFull    = 13'd5760;
  localparam int               SectorSpan = 960;
  localparam logic [ProdW-1:0] ScaleD     = 18'd244800;

  localparam longint unsigned RecipFull = ((64'd1 << RecipK) + 64'd244800 - 64'd1) / 64'd244800;
  localparam logic [RecipW-1:0] RecipM = RecipFull[RecipW-1:0];

  localparam logic [IdxW-1:0] RegSaturation = 8'd0;
  localparam logic [IdxW-1:0] RegBrightness = 8'd1;

  localparam logic [ChanW-1:0] SatReset = 8'd255;
  localparam logic [ChanW-1:0] BriReset = 8'd26;

  typedef logic [SecW-1:0] sector_t;

  typedef struct packed {
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] bri;
  } cfg_t;

endpackage

[design/hsv_cfg.sv]
// ----------------------------------------------------------------------------
// hsv_cfg
// Saturation and brightness registers behind the configuration write channel.
// ----------------------------------------------------------------------------
module hsv_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hsv_pkg::IdxW-1:0]  cfg_index,
  input  logic [hsv_pkg::ChanW-1:0] cfg_data,
  output hsv_pkg::cfg_t             cfg
);
  import hsv_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sat <= SatReset;
      cfg.bri <= BriReset;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == RegSaturation) begin
        cfg.sat <= cfg_data;
      end else if (cfg_index == RegBrightness) begin
        cfg.bri <= cfg_data;
      end
    end
  end

endmodule

[design/hsv_pipe.sv]
// ----------------------------------------------------------------------------
// hsv_pipe
// Five-stage conversion pipeline: sector split, products, levels,
// reciprocal divide, channel select. Each stage holds its own valid bit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_pipe (
  input  logic                      clk,
  input  logic                      rst,
  input  hsv_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [hsv_pkg::HueW-1:0]  hue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hsv_pkg::ChanW-1:0] red,
  output logic [hsv_pkg::ChanW-1:0] green,
  output logic [hsv_pkg::ChanW-1:0] blue
);
  import hsv_pkg::*;

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4, adv5;

  // stage 1
  sector_t          sec1;
  logic [RemW-1:0]  rem1;
  logic             gray1, black1;
  sector_t          sec_next;
  logic [RemW-1:0]  rem_next;
  logic [HueW-1:0]  hz;

  // stage 2
  sector_t          sec2;
  logic             gray2, black2;
  logic [ProdW-1:0] pa2, pb2;
  logic [2*ChanW-1:0] xa2;

  // stage 3
  sector_t          sec3;
  logic             gray3, black3;
  logic [LevelW-1:0] na3, nb3;
  logic [ChanW-1:0] aa3;
  logic [2*ChanW:0] aa_sum;

  // stage 4
  sector_t          sec4;
  logic             gray4, black4;
  logic [ChanW-1:0] aa4, bb4, cc4;
  logic [LevelW+RecipW-1:0] qa_full, qb_full;

  // stage 5
  logic             black5;
  logic [ChanW-1:0] r_next, g_next, b_next;

  assign adv5     = !out_valid || out_ready;
  assign adv4     = !v4 || adv5;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_comb begin
    hz = (hue == HueFull) ? '0 : hue;
    priority if (hz >= HueW'(SectorSpan * 5)) begin
      sec_next = 3'd5;
      rem_next = RemW'(hz - HueW'(SectorSpan * 5));
    end else if (hz >= HueW'(SectorSpan * 4)) begin
      sec_next = 3'd4;
      rem_next = RemW'(hz - HueW'(SectorSpan * 4));
    end else if (hz >= HueW'(SectorSpan * 3)) begin
      sec_next = 3'd3;
      rem_next = RemW'(hz - HueW'(SectorSpan * 3));
    end else if (hz >= HueW'(SectorSpan * 2)) begin
      sec_next = 3'd2;
      rem_next = RemW'(hz - HueW'(SectorSpan * 2));
    end else if (hz >= HueW'(SectorSpan)) begin
      sec_next = 3'd1;
      rem_next = RemW'(hz - HueW'(SectorSpan));
    end else begin
      sec_next = 3'd0;
      rem_next = RemW'(hz);
    end
  end

  // floor(x/255) for 16-bit x
  assign aa_sum = {1'b0, xa2} + {9'd0, xa2[2*ChanW-1:ChanW]} + 17'd1;

  assign qa_full = LevelW'(na3) * RecipM;
  assign qb_full = LevelW'(nb3) * RecipM;

  always_comb begin
    unique case (sec4)
      3'd0: begin r_next = cfg.bri; g_next = cc4;     b_next = aa4;     end
      3'd1: begin r_next = bb4;     g_next = cfg.bri; b_next = aa4;     end
      3'd2: begin r_next = aa4;     g_next = cfg.bri; b_next = cc4;     end
      3'd3: begin r_next = aa4;     g_next = bb4;     b_next = cfg.bri; end
      3'd4: begin r_next = cc4;     g_next = aa4;     b_next = cfg.bri; end
      default: begin r_next = cfg.bri; g_next = aa4;  b_next = bb4;     end
    endcase
    if (gray4) begin
      r_next = cfg.bri;
      g_next = cfg.bri;
      b_next = cfg.bri;
    end else if (black4) begin
      r_next = '0;
      g_next = '0;
      b_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      sec1   <= sec_next;
      rem1   <= rem_next;
      gray1  <= (cfg.sat == '0);
      black1 <= (hue > HueFull);
    end
    if (adv2 && v1) begin
      sec2   <= sec1;
      gray2  <= gray1;
      black2 <= black1;
      pa2    <= ProdW'(cfg.sat) * ProdW'(rem1);
      pb2    <= ProdW'(cfg.sat) * ProdW'(RemW'(SectorSpan) - rem1);
      xa2    <= (2*ChanW)'(cfg.bri) * (2*ChanW)'(8'd255 - cfg.sat);
    end
    if (adv3 && v2) begin
      sec3   <= sec2;
      gray3  <= gray2;
      black3 <= black2;
      na3    <= LevelW'(cfg.bri) * LevelW'(ScaleD - pa2);
      nb3    <= LevelW'(cfg.bri) * LevelW'(ScaleD - pb2);
      aa3    <= aa_sum[2*ChanW-1:ChanW];
    end
    if (adv4 && v3) begin
      sec4   <= sec3;
      gray4  <= gray3;
      black4 <= black3;
      aa4    <= aa3;
      bb4    <= qa_full[RecipK+ChanW-1:RecipK];
      cc4    <= qb_full[RecipK+ChanW-1:RecipK];
    end
    if (adv5 && v4) begin
      black5 <= black4 && !gray4;
      red    <= r_next;
      green  <= g_next;
      blue   <= b_next;
    end
  end

  `ASSERT_NEXT(a_enter, in_valid && in_ready, v1)
  `ASSERT_SAME(a_gray, out_valid && cfg.sat == '0, red == cfg.bri && green == cfg.bri && blue == cfg.bri)
  `ASSERT_SAME(a_peak, out_valid && !black5, red == cfg.bri || green == cfg.bri || blue == cfg.bri)
  `ASSERT_SAME(a_black, out_valid && black5, red == '0 && green == '0 && blue == '0)

endmodule

[design/hsv_to_rgb_converter_top.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV to RGB pixel converter with programmable saturation and brightness.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one 13-bit hue (1/16 degree,
//   0..5760, 5760 same as 0). Output channel out_valid/out_ready returns
//   8-bit red, green and blue for each hue, in order.
//   Config channel cfg_valid/cfg_ready writes saturation (index 0) or
//   brightness (index 1); other indexes are dropped. cfg_ready is always
//   high. Write config only while no transaction is in flight.
//   Throughput: one transaction per cycle while out_ready is high (a low
//   out_ready stalls the pipe), set by the five-stage pipeline (sector split,
//   products, levels, reciprocal multiply, select).
//   Reset: saturation 255, brightness 26, pipeline emptied.
//   Receiver stall: each stage holds until the next one frees up; empty
//   stages keep filling, so in_ready drops only once all five are full.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hsv_pkg::IdxW-1:0]  cfg_index,
  input  logic [hsv_pkg::ChanW-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [hsv_pkg::HueW-1:0]  hue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hsv_pkg::ChanW-1:0] red,
  output logic [hsv_pkg::ChanW-1:0] green,
  output logic [hsv_pkg::ChanW-1:0] blue
);
  import hsv_pkg::*;

  cfg_t cfg;

  hsv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hsv_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hue       (hue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HSV to RGB pixel converter. Hues are streamed
// in bursts against a stalling receiver; every returned pixel is compared
// channel by channel with a fixed-point color predictor held in the bench.
// Saturation and brightness are reprogrammed between drained phases.
// ----------------------------------------------------------------------------
module testbench;
  import hsv_pkg::*;

  localparam int          RandomPerPhase = 280;
  localparam int          HoldCycles     = 80;
  localparam int          PressureItems  = 40;
  localparam logic [IdxW-1:0] RegUnused  = 8'd2;
  localparam logic [IdxW-1:0] RegTop     = 8'hFF;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  typedef enum int unsigned {
    SecRedYellow, SecYellowGreen, SecGreenCyan, SecCyanBlue, SecBlueMagenta, SecMagentaRed
  } sector_e;

  typedef enum logic [1:0] {RxAlways, RxCoin, RxPattern} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IdxW-1:0]  cfg_index = '0;
  logic [ChanW-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [HueW-1:0]  hue = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  logic [ChanW-1:0] sat_reg = SatReset;
  logic [ChanW-1:0] bri_reg = BriReset;
  rgb_t             rgb_expected[$];
  rgb_t             rgb_head;
  int               mismatch_count = 0;
  bit               offering = 1'b0;
  bit               tx_gaps = 1'b1;
  int               burst_left = 0;
  rx_mode_t         rx_mode = RxAlways;
  logic             rx_hold = 1'b0;
  logic [2:0]       rx_count = '0;

  hsv_to_rgb_converter_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hue       (hue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(500_000 * 12);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned shade(int unsigned v, int unsigned s, int unsigned frac);
    return (v * (ScaleD - s * frac)) / ScaleD;
  endfunction

  function automatic rgb_t hsv_to_rgb(logic [HueW-1:0] h, logic [ChanW-1:0] s,
                                      logic [ChanW-1:0] v);
    int unsigned hh;
    int unsigned rem;
    int unsigned aa;
    int unsigned bb;
    int unsigned cc;
    rgb_t        c;
    hh = h;
    c  = '0;
    if (s == 0) begin
      c = '{v, v, v};
    end else if (hh <= HueFull) begin
      if (hh == HueFull) hh = 0;
      rem = hh % SectorSpan;
      aa  = (v * (255 - s)) / 255;
      bb  = shade(v, s, rem);
      cc  = shade(v, s, SectorSpan - rem);
      case (hh / SectorSpan)
        SecRedYellow:   c = '{v, ChanW'(cc), ChanW'(aa)};
        SecYellowGreen: c = '{ChanW'(bb), v, ChanW'(aa)};
        SecGreenCyan:   c = '{ChanW'(aa), v, ChanW'(cc)};
        SecCyanBlue:    c = '{ChanW'(aa), ChanW'(bb), v};
        SecBlueMagenta: c = '{ChanW'(cc), ChanW'(aa), v};
        default:        c = '{v, ChanW'(aa), ChanW'(bb)};
      endcase
    end
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // output checker
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (rgb_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction r=%0d g=%0d b=%0d",
                                  red, green, blue));
      end else begin
        rgb_head = rgb_expected.pop_front();
        if (red !== rgb_head.r)
          report_mismatch($sformatf("red got %0d want %0d", red, rgb_head.r));
        if (green !== rgb_head.g)
          report_mismatch($sformatf("green got %0d want %0d", green, rgb_head.g));
        if (blue !== rgb_head.b)
          report_mismatch($sformatf("blue got %0d want %0d", blue, rgb_head.b));
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    rx_count <= rx_count + 3'd1;
    if (rx_hold) begin
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RxCoin:    out_ready <= ($urandom_range(0, 3) != 0);
        RxPattern: out_ready <= (rx_count < 3'd5);
        default:   out_ready <= 1'b1;
      endcase
    end
  end

  task automatic write_reg(logic [IdxW-1:0] idx, logic [ChanW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == RegSaturation) sat_reg = data;
    else if (idx == RegBrightness) bri_reg = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic sender_idle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_hue(logic [HueW-1:0] h);
    int gap;
    if (!offering) begin
      in_valid <= 1'b1;
      offering = 1'b1;
    end
    hue <= h;
    do @(posedge clk); while (!in_ready);
    rgb_expected.push_back(hsv_to_rgb(h, sat_reg, bri_reg));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = tx_gaps ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        sender_idle();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_results();
    sender_idle();
    while (rgb_expected.size() != 0) @(posedge clk);
  endtask

  function automatic logic [HueW-1:0] pick_hue();
    int unsigned sel;
    int unsigned edge_pick;
    sel = $urandom_range(0, 99);
    if (sel < 80) return HueW'($urandom_range(0, HueFull));
    if (sel < 90) return HueW'($urandom_range(0, (1 << HueW) - 1));
    edge_pick = $urandom_range(0, 3);
    return HueW'($urandom_range(0, 6) * SectorSpan + ((edge_pick < 2) ? edge_pick
                                                      : SectorSpan - 4 + edge_pick));
  endfunction

  task automatic test_reset_defaults();
    send_hue(13'd0);
    send_hue(13'd3000);
    send_hue(HueFull);
    wait_results();
  endtask

  task automatic test_corners();
    logic [HueW-1:0] full_sat_hues[12] = '{0, 480, 959, 960, 1920, 2880, 3840, 4800,
                                           5759, 5760, 5761, 8191};
    write_reg(RegSaturation, 8'd255);
    write_reg(RegBrightness, 8'd255);
    foreach (full_sat_hues[i]) send_hue(full_sat_hues[i]);
    wait_results();
    // gray: hue has no effect, even out of range
    write_reg(RegSaturation, 8'd0);
    write_reg(RegBrightness, 8'd200);
    send_hue(13'd0);
    send_hue(13'd8191);
    send_hue(HueFull);
    wait_results();
    write_reg(RegSaturation, 8'd1);
    write_reg(RegBrightness, 8'd255);
    send_hue(13'd959);
    send_hue(13'd4321);
    wait_results();
    write_reg(RegSaturation, 8'd128);
    write_reg(RegBrightness, 8'd0);
    send_hue(13'd2000);
    wait_results();
  endtask

  task automatic test_ignored_index();
    write_reg(RegSaturation, 8'd200);
    write_reg(RegBrightness, 8'd100);
    write_reg(RegUnused, 8'd0);
    write_reg(RegTop, 8'd0);
    send_hue(13'd1000);
    send_hue(13'd5000);
    wait_results();
  endtask

  task automatic test_random_settings();
    logic [ChanW-1:0] sat_set[4] = '{255, 0, 1, 128};
    logic [ChanW-1:0] bri_set[4] = '{255, 255, 0, 77};
    rx_mode_t         rx_set[6]  = '{RxCoin, RxPattern, RxCoin, RxAlways, RxPattern, RxCoin};
    for (int p = 0; p < 6; p++) begin
      write_reg(RegSaturation, (p < 4) ? sat_set[p] : ChanW'($urandom_range(0, 255)));
      write_reg(RegBrightness, (p < 4) ? bri_set[p] : ChanW'($urandom_range(0, 255)));
      rx_mode <= rx_set[p];
      tx_gaps = (p != 3);
      for (int i = 0; i < RandomPerPhase; i++) begin
        send_hue(pick_hue());
        if (p == 2 && i == RandomPerPhase / 2) wait_results();
      end
      wait_results();
    end
    tx_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    write_reg(RegSaturation, 8'd180);
    write_reg(RegBrightness, 8'd240);
    rx_mode <= RxAlways;
    tx_gaps = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < PressureItems; i++) send_hue(pick_hue());
    wait fork;
    wait_results();
    tx_gaps = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_corners();
    test_ignored_index();
    test_backpressure();
    test_random_settings();
    wait_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/hsv_pkg.sv
design/hsv_cfg.sv
design/hsv_pipe.sv
design/hsv_to_rgb_converter_top.sv
tb/testbench.sv
